// ----- hw/rtl/bbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, widths and codes of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int KNOT_W        = 32;
    localparam int FRAC_BITS     = 16;
    localparam int BASIS_W       = 17;
    localparam logic [16:0] ONE  = 17'h10000;
    localparam int MAX_KNOTS_DEF = 32;
    localparam int MAX_DEGREE    = 3;
    localparam int MAX_RESULTS   = 31;
    localparam int IDX_W         = 5;
    localparam int BASIS_DEPTH   = 32;
    localparam int X_W           = 34;   // clamped sample
    localparam int DIST_W        = 35;   // sample minus knot
    localparam int MAG_W         = 34;
    localparam int DEN_W         = 33;   // knot span
    localparam int DVS_W         = 32;   // positive span magnitude
    localparam int PROD_W        = 51;
    localparam int SUM_W         = 53;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;

    localparam logic [2:0] KSEL_ZERO = 3'd0;
    localparam logic [2:0] KSEL_LAST = 3'd1;
    localparam logic [2:0] KSEL_I    = 3'd2;
    localparam logic [2:0] KSEL_IP   = 3'd3;
    localparam logic [2:0] KSEL_I1   = 3'd4;
    localparam logic [2:0] KSEL_IP1  = 3'd5;

    localparam logic BSEL_I  = 1'b0;
    localparam logic BSEL_I1 = 1'b1;

    typedef struct packed {
        logic             knot_we;
        logic             eval_start;
        logic [2:0]       ksel;
        logic             bsel;
        logic [IDX_W-1:0] i;
        logic [1:0]       p;
        logic             side;
        logic             cap_ka;
        logic             cap_kb;
        logic             cap_kc;
        logic             cap_ba;
        logic             cap_bb;
        logic             clamp;
        logic             pre;
        logic             mul;
        logic             div_start;
        logic             acc;
        logic             sum_clr;
        logic             wr_ind;
        logic             wr_sum;
        logic             emit;
        logic             emit_nob;
    } bbe_cmd_t;

    typedef struct packed {
        logic       nb_zero;
        logic       last_i;
        logic [1:0] deg;
        logic       den_l_ok;
        logic       den_r_ok;
        logic       div_done;
    } bbe_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bspline_basis_evaluator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_unit
// Cox-de Boor B-spline basis evaluator over a loaded knot table.
// ----------------------------------------------------------------------------
// Load item: busy stays low, no result.
// Evaluate item: a clamp step, a degree-zero pass per basis, then per basis
//   and level a term setup plus a 51-bit serial divide per term whose span
//   exceeds the tolerance, then the results, one per basis.
// No-basis case: a single flagged result, marked last.
// Reset clears control and configuration; the knot table holds no reset.
// Results are strobed for one cycle; the receiver cannot stall them.
module bspline_basis_evaluator_unit #(
    parameter int MAX_KNOTS = bbe_pkg::MAX_KNOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               opcode,
    input  wire logic [4:0]         knot_index,
    input  wire logic signed [31:0] knot_value,
    input  wire logic signed [31:0] sample_x,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    // result strobe and payload
    output logic                    result_valid,
    output logic [4:0]              basis_index,
    output logic [16:0]             basis_value,
    output logic                    no_basis,
    output logic                    last
);

    // Configuration registers: to be written only while idle (the block does not
    // enforce it), so the datapath reads them directly through a whole evaluation.
    logic [1:0] degree_reg;
    logic [5:0] count_reg;
    logic [7:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 2'd3;
            count_reg  <= 6'd8;
            tol_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbe_pkg::CFG_DEGREE: degree_reg <= cfg_data[1:0];
                bbe_pkg::CFG_COUNT:  count_reg  <= cfg_data[5:0];
                bbe_pkg::CFG_TOL:    tol_reg    <= cfg_data;
                default:             tol_reg    <= tol_reg;  // drop unknown index
            endcase
        end
    end

    bbe_pkg::bbe_cmd_t cmd;
    bbe_pkg::bbe_sts_t sts;
    logic              accept;

    // gate start with busy so an item arriving mid-evaluation is ignored
    assign accept = start & ~busy;

    bbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    bbe_datapath #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .knot_index   (knot_index),
        .knot_value   (knot_value),
        .sample_x     (sample_x),
        .cfg_degree   (degree_reg),
        .cfg_count    (count_reg),
        .cfg_tol      (tol_reg),
        .result_valid (result_valid),
        .basis_index  (basis_index),
        .basis_value  (basis_value),
        .no_basis     (no_basis),
        .last         (last)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/bbe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bbe_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbe_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bbe_pkg::PROD_W-1:0] dividend,
    input  wire logic [bbe_pkg::DVS_W-1:0]  divisor,
    output logic      [bbe_pkg::PROD_W-1:0] quotient,
    output logic                           done
);

    localparam int CW = $clog2(bbe_pkg::PROD_W);
    localparam logic [CW-1:0] LAST_CNT = CW'(bbe_pkg::PROD_W - 1);

    logic [bbe_pkg::PROD_W-1:0] quo_reg;
    logic [bbe_pkg::DVS_W-1:0]  rem_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [bbe_pkg::DVS_W:0]    shifted;
    logic [bbe_pkg::DVS_W:0]    diff;

    assign shifted = {rem_reg, quo_reg[bbe_pkg::PROD_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            // subtract when the shifted remainder covers the divisor
            if (!diff[bbe_pkg::DVS_W])
            begin
                rem_reg <= diff[bbe_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[bbe_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[bbe_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[bbe_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/bbe_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_datapath
// Knot and basis memories, clamp, indicator, term product, divider, sum.
// ----------------------------------------------------------------------------
module bbe_datapath #(
    parameter int MAX_KNOTS = bbe_pkg::MAX_KNOTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bbe_pkg::bbe_cmd_t           cmd,
    output bbe_pkg::bbe_sts_t                sts,
    input  wire logic [4:0]                  knot_index,
    input  wire logic signed [31:0]          knot_value,
    input  wire logic signed [31:0]          sample_x,
    input  wire logic [1:0]                  cfg_degree,
    input  wire logic [5:0]                  cfg_count,
    input  wire logic [7:0]                  cfg_tol,
    output logic                             result_valid,
    output logic [4:0]                       basis_index,
    output logic [16:0]                      basis_value,
    output logic                             no_basis,
    output logic                             last
);

    localparam int KA_W = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int BA_W = $clog2(bbe_pkg::BASIS_DEPTH);

    // ---- configuration derived values
    logic [6:0]        count_ext;
    logic [6:0]        n_knots;
    logic [1:0]        deg;
    logic signed [7:0] nb_s;
    logic [4:0]        nb_cap;
    logic              last_i;

    assign count_ext = {1'b0, cfg_count};
    assign n_knots   = (count_ext > 7'(MAX_KNOTS)) ? 7'(MAX_KNOTS) : count_ext;
    assign deg       = ({1'b0, cfg_degree} > 3'(bbe_pkg::MAX_DEGREE))
                       ? 2'(bbe_pkg::MAX_DEGREE) : cfg_degree;
    assign nb_s      = $signed({1'b0, n_knots}) - $signed({6'b0, deg}) - 8'sd1;
    assign nb_cap    = (nb_s > 8'sd31) ? 5'd31 : nb_s[4:0];
    assign last_i    = (cmd.i == (nb_cap - 5'd1));

    // ---- knot table
    logic [6:0]        kaddr;
    logic [6:0]        kidx_ext;
    logic              knot_wen;
    logic [31:0]       knot_rdata;
    logic signed [31:0] krd;

    always_comb
    begin
        case (cmd.ksel)
            bbe_pkg::KSEL_ZERO: kaddr = 7'd0;
            bbe_pkg::KSEL_LAST: kaddr = n_knots - 7'd1;
            bbe_pkg::KSEL_I:    kaddr = {2'b0, cmd.i};
            bbe_pkg::KSEL_IP:   kaddr = {2'b0, cmd.i} + {5'b0, cmd.p};
            bbe_pkg::KSEL_I1:   kaddr = {2'b0, cmd.i} + 7'd1;
            bbe_pkg::KSEL_IP1:  kaddr = {2'b0, cmd.i} + {5'b0, cmd.p} + 7'd1;
            default:            kaddr = 7'd0;
        endcase
    end

    assign kidx_ext = {2'b0, knot_index};
    assign knot_wen = cmd.knot_we && (kidx_ext < 7'(MAX_KNOTS));
    assign krd      = $signed(knot_rdata);

    bbe_ram #(
        .WIDTH (bbe_pkg::KNOT_W),
        .DEPTH (MAX_KNOTS)
    ) u_knot_ram (
        .clk   (clk),
        .we    (knot_wen),
        .waddr (kidx_ext[KA_W-1:0]),
        .wdata (knot_value),
        .raddr (kaddr[KA_W-1:0]),
        .rdata (knot_rdata)
    );

    // ---- working registers
    logic [31:0]        x_raw_reg;
    logic signed [33:0] x_reg;
    logic signed [31:0] right_reg;
    logic signed [31:0] ka_reg;
    logic signed [31:0] kb_reg;
    logic signed [31:0] kc_reg;
    logic [16:0]        ba_reg;
    logic [16:0]        bb_reg;
    logic signed [34:0] dist_l_reg;
    logic signed [34:0] dist_r_reg;
    logic signed [32:0] den_l_reg;
    logic signed [32:0] den_r_reg;
    logic [50:0]        prod_reg;
    logic               neg_reg;
    logic [31:0]        dvs_reg;
    logic signed [52:0] sum_reg;

    // ---- clamp
    logic signed [33:0] xs;
    logic signed [33:0] left34;
    logic signed [33:0] right34;
    logic signed [33:0] rlim;
    logic signed [33:0] x1;
    logic signed [33:0] x2;

    assign xs      = $signed({{2{x_raw_reg[31]}}, x_raw_reg});
    assign left34  = 34'(ka_reg);
    assign right34 = 34'(krd);
    assign rlim    = right34 - $signed({26'b0, cfg_tol});
    assign x1      = (xs < left34) ? left34 : xs;
    assign x2      = (x1 > rlim) ? rlim : x1;

    // ---- degree zero indicator
    logic signed [34:0] x35;
    logic signed [34:0] dend;
    logic signed [34:0] tol35;
    logic               ind_on;

    assign x35    = 35'(x_reg);
    assign dend   = x35 - 35'(right_reg);
    assign tol35  = $signed({27'b0, cfg_tol});
    assign ind_on = ((x_reg >= 34'(ka_reg)) && (x_reg < 34'(krd)))
                    || (last_i && (dend <= tol35) && (dend >= -tol35));

    // ---- term setup and product
    logic signed [32:0] tol33;
    logic signed [34:0] dist_sel;
    logic [34:0]        mag35;
    logic [16:0]        bsel_val;
    logic [50:0]        prod_w;

    assign tol33    = $signed({25'b0, cfg_tol});
    assign dist_sel = cmd.side ? dist_r_reg : dist_l_reg;
    assign mag35    = dist_sel[34] ? 35'(-dist_sel) : 35'(dist_sel);
    assign bsel_val = cmd.side ? bb_reg : ba_reg;
    assign prod_w   = {17'b0, mag35[33:0]} * {34'b0, bsel_val};

    // ---- divider and accumulate
    logic [50:0]        quo;
    logic               div_done;
    logic signed [52:0] term;
    logic [16:0]        sat_val;

    bbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .quotient (quo),
        .done     (div_done)
    );

    assign term    = neg_reg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    assign sat_val = sum_reg[52] ? 17'd0
                   : ((sum_reg > $signed({36'b0, bbe_pkg::ONE})) ? bbe_pkg::ONE
                                                               : sum_reg[16:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start) x_raw_reg <= sample_x;
        if (cmd.cap_ka)     ka_reg    <= krd;
        if (cmd.cap_kb)     kb_reg    <= krd;
        if (cmd.cap_kc)     kc_reg    <= krd;
        if (cmd.clamp)
        begin
            x_reg     <= x2;
            right_reg <= krd;
        end
        if (cmd.pre)
        begin
            dist_l_reg <= x35 - 35'(ka_reg);
            den_l_reg  <= 33'(kb_reg) - 33'(ka_reg);
            dist_r_reg <= 35'(krd) - x35;
            den_r_reg  <= 33'(krd) - 33'(kc_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_w;
            neg_reg  <= dist_sel[34];
            dvs_reg  <= cmd.side ? den_r_reg[31:0] : den_l_reg[31:0];
        end
        if (cmd.sum_clr)
            sum_reg <= '0;
        else if (cmd.acc && div_done)
            sum_reg <= sum_reg + term;
    end

    // ---- basis store
    logic [16:0] basis_rdata;
    logic [4:0]  baddr;
    logic [16:0] bwdata;

    assign baddr  = (cmd.bsel == bbe_pkg::BSEL_I1) ? (cmd.i + 5'd1) : cmd.i;
    assign bwdata = cmd.wr_ind ? (ind_on ? bbe_pkg::ONE : 17'd0) : sat_val;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_ba) ba_reg <= basis_rdata;
        if (cmd.cap_bb) bb_reg <= basis_rdata;
    end

    bbe_ram #(
        .WIDTH (bbe_pkg::BASIS_W),
        .DEPTH (bbe_pkg::BASIS_DEPTH)
    ) u_basis_ram (
        .clk   (clk),
        .we    (cmd.wr_ind | cmd.wr_sum),
        .waddr (cmd.i[BA_W-1:0]),
        .wdata (bwdata),
        .raddr (baddr[BA_W-1:0]),
        .rdata (basis_rdata)
    );

    // ---- result registers
    logic        rv_reg;
    logic [4:0]  ridx_reg;
    logic [16:0] rval_reg;
    logic        rnob_reg;
    logic        rlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= cmd.emit | cmd.emit_nob;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ridx_reg  <= cmd.i;
            rval_reg  <= basis_rdata;
            rnob_reg  <= 1'b0;
            rlast_reg <= last_i;
        end
        else if (cmd.emit_nob)
        begin
            ridx_reg  <= 5'd0;
            rval_reg  <= 17'd0;
            rnob_reg  <= 1'b1;
            rlast_reg <= 1'b1;
        end
    end

    assign result_valid = rv_reg;
    assign basis_index  = ridx_reg;
    assign basis_value  = rval_reg;
    assign no_basis     = rnob_reg;
    assign last         = rlast_reg;

    // ---- status
    assign sts.nb_zero  = nb_s[7] || (nb_s == 8'sd0);
    assign sts.last_i   = last_i;
    assign sts.deg      = deg;
    assign sts.den_l_ok = den_l_reg > tol33;
    assign sts.den_r_ok = den_r_reg > tol33;
    assign sts.div_done = div_done;

endmodule
`default_nettype wire

// ----- hw/rtl/bbe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_ctrl
// Sequencer: knot load, no-basis result, clamp, degree-zero pass, recursion levels, result output.
// ----------------------------------------------------------------------------
module bbe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              opcode,
    input  wire bbe_pkg::bbe_sts_t sts,
    output bbe_pkg::bbe_cmd_t      cmd,
    output logic                   busy
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_NOB  = 5'd1;
    localparam logic [4:0] S_EK0  = 5'd2;
    localparam logic [4:0] S_EKL  = 5'd3;
    localparam logic [4:0] S_ECL  = 5'd4;
    localparam logic [4:0] S_Z0   = 5'd5;
    localparam logic [4:0] S_Z1   = 5'd6;
    localparam logic [4:0] S_Z2   = 5'd7;
    localparam logic [4:0] S_R0   = 5'd8;
    localparam logic [4:0] S_R1   = 5'd9;
    localparam logic [4:0] S_R2   = 5'd10;
    localparam logic [4:0] S_R3   = 5'd11;
    localparam logic [4:0] S_R4   = 5'd12;
    localparam logic [4:0] S_DEC  = 5'd13;
    localparam logic [4:0] S_MUL  = 5'd14;
    localparam logic [4:0] S_DVS  = 5'd15;
    localparam logic [4:0] S_DVW  = 5'd16;
    localparam logic [4:0] S_WR   = 5'd17;
    localparam logic [4:0] S_O0   = 5'd18;
    localparam logic [4:0] S_O1   = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [4:0] i_reg, i_next;
    logic [1:0] p_reg, p_next;
    logic       side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            p_reg     <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            p_reg     <= p_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.i      = i_reg;
        cmd.p      = p_reg;
        cmd.side   = side_reg;
        cmd.ksel   = bbe_pkg::KSEL_I;
        cmd.bsel   = bbe_pkg::BSEL_I;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == bbe_pkg::OP_EVAL)
                    begin
                        cmd.eval_start = 1'b1;
                        state_next     = sts.nb_zero ? S_NOB : S_EK0;
                    end
                    else
                    begin
                        cmd.knot_we = 1'b1;
                    end
                end
            end
            S_NOB:
            begin
                cmd.emit_nob = 1'b1;
                state_next   = S_IDLE;
            end
            S_EK0:
            begin
                cmd.ksel   = bbe_pkg::KSEL_ZERO;
                state_next = S_EKL;
            end
            S_EKL:
            begin
                cmd.ksel   = bbe_pkg::KSEL_LAST;
                cmd.cap_ka = 1'b1;
                state_next = S_ECL;
            end
            S_ECL:
            begin
                cmd.clamp  = 1'b1;
                i_next     = '0;
                state_next = S_Z0;
            end
            S_Z0:
            begin
                state_next = S_Z1;
            end
            S_Z1:
            begin
                cmd.ksel   = bbe_pkg::KSEL_I1;
                cmd.cap_ka = 1'b1;
                state_next = S_Z2;
            end
            S_Z2:
            begin
                cmd.wr_ind = 1'b1;
                if (sts.last_i)
                begin
                    i_next = '0;
                    if (sts.deg == 2'd0)
                    begin
                        state_next = S_O0;
                    end
                    else
                    begin
                        p_next     = 2'd1;
                        state_next = S_R0;
                    end
                end
                else
                begin
                    i_next     = i_reg + 5'd1;
                    state_next = S_Z0;
                end
            end
            S_R0:
            begin
                cmd.sum_clr = 1'b1;
                state_next  = S_R1;
            end
            S_R1:
            begin
                cmd.ksel   = bbe_pkg::KSEL_IP;
                cmd.cap_ka = 1'b1;
                cmd.cap_ba = 1'b1;
                state_next = S_R2;
            end
            S_R2:
            begin
                cmd.ksel   = bbe_pkg::KSEL_I1;
                cmd.bsel   = bbe_pkg::BSEL_I1;
                cmd.cap_kb = 1'b1;
                state_next = S_R3;
            end
            S_R3:
            begin
                cmd.ksel   = bbe_pkg::KSEL_IP1;
                cmd.cap_kc = 1'b1;
                cmd.cap_bb = 1'b1;
                state_next = S_R4;
            end
            S_R4:
            begin
                cmd.pre    = 1'b1;
                side_next  = 1'b0;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.den_l_ok)
                begin
                    state_next = S_MUL;
                end
                else if (!sts.last_i && sts.den_r_ok)
                begin
                    side_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DVS;
            end
            S_DVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DVW;
            end
            S_DVW:
            begin
                cmd.acc = 1'b1;
                if (sts.div_done)
                begin
                    if (!side_reg && !sts.last_i && sts.den_r_ok)
                    begin
                        side_next  = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
            end
            S_WR:
            begin
                cmd.wr_sum = 1'b1;
                if (sts.last_i)
                begin
                    i_next = '0;
                    if (p_reg == sts.deg)
                    begin
                        state_next = S_O0;
                    end
                    else
                    begin
                        p_next     = p_reg + 2'd1;
                        state_next = S_R0;
                    end
                end
                else
                begin
                    i_next     = i_reg + 5'd1;
                    state_next = S_R0;
                end
            end
            S_O0:
            begin
                state_next = S_O1;
            end
            S_O1:
            begin
                cmd.emit = 1'b1;
                if (sts.last_i)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 5'd1;
                    state_next = S_O0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/bbe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_checker
// Port-level checks of the basis evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bbe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        opcode,
    input wire logic        result_valid,
    input wire logic [16:0] basis_value,
    input wire logic        no_basis,
    input wire logic        last
);

    // a flagged result stands alone
    a_nob_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_basis |-> last)
        else $error("no_basis result without last");

    // results only come out of an evaluation in progress
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a running evaluation");

    // a knot load produces nothing
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == bbe_pkg::OP_LOAD |=> !result_valid)
        else $error("result after knot load");

    // the unit stays busy after a non-final result
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> busy)
        else $error("evaluation ended before last result");

    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> basis_value <= bbe_pkg::ONE)
        else $error("basis value above one");

endmodule

bind bspline_basis_evaluator_unit bbe_checker u_bbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .basis_value  (basis_value),
    .no_basis     (no_basis),
    .last         (last)
);
`default_nettype wire
